// File: rtl/core/btd_pkg.sv
// Shared constants, command and action codes, and payload types for the
// bounded task dispatcher. No dependencies.
`default_nettype none

package btd_pkg;

    // Sizing
    localparam int RUN_SLOTS  = 16;
    localparam int PEND_DEPTH = 64;
    localparam int ID_BITS    = 8;

    localparam int SLOT_W     = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RUN_CNT_W  = $clog2(RUN_SLOTS + 1);
    localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int CMD_W      = 3;
    localparam int ACT_W      = 3;

    localparam logic [CFG_W-1:0] MAX_RUNNING_RESET = CFG_W'(5);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_FINISHED = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_FAILED   = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_KILL     = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_REFILL   = CMD_W'(4);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_START    = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_INLINE   = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_QUEUED   = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_FINALIZE = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_DELETE   = ACT_W'(4);
    localparam logic [ACT_W-1:0] ACT_UNKNOWN  = ACT_W'(5);
    localparam logic [ACT_W-1:0] ACT_REJECT   = ACT_W'(6);
    localparam logic [ACT_W-1:0] ACT_CLEARED  = ACT_W'(7);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_BITS-1:0] task_id;
    } task_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [ID_BITS-1:0]    out_task_id;
        logic                  last;
        logic [RUN_CNT_W-1:0]  running_count;
        logic [PEND_CNT_W-1:0] pending_count;
    } result_item_t;

    // Control into the running set
    typedef struct packed {
        logic               clr;
        logic               ins;
        logic               rem;
        logic [ID_BITS-1:0] ins_id;
        logic [ID_BITS-1:0] rem_id;
    } run_ctl_t;

    // Status out of the running set
    typedef struct packed {
        logic                 full;
        logic                 hit;
        logic [RUN_CNT_W-1:0] level;
    } run_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/btd_run_set.sv
// Running set: slot ids with per-slot valid bits, first-free insert and
// first-match remove. Depends on btd_pkg.
`default_nettype none

module btd_run_set (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire btd_pkg::run_ctl_t ctl,
    output btd_pkg::run_stat_t     stat
);

    logic [btd_pkg::ID_BITS-1:0]   ids_reg [btd_pkg::RUN_SLOTS];
    logic [btd_pkg::RUN_SLOTS-1:0] valid_reg, valid_next;
    logic [btd_pkg::RUN_CNT_W-1:0] level_reg, level_next;

    logic [btd_pkg::SLOT_W-1:0] free_idx;
    logic [btd_pkg::SLOT_W-1:0] hit_idx;
    logic                       hit;

    // Lowest free slot and lowest valid slot holding the id to remove
    always_comb
    begin
        free_idx = '0;
        hit_idx  = '0;
        hit      = 1'b0;
        for (int i = btd_pkg::RUN_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = btd_pkg::SLOT_W'(i);
            end
            if (valid_reg[i] && (ids_reg[i] == ctl.rem_id))
            begin
                hit_idx = btd_pkg::SLOT_W'(i);
                hit     = 1'b1;
            end
        end
    end

    assign stat.full  = &valid_reg;
    assign stat.hit   = hit;
    assign stat.level = level_reg;

    // Next valid bits and level
    always_comb
    begin
        valid_next = valid_reg;
        level_next = level_reg;
        if (ctl.clr)
        begin
            valid_next = '0;
            level_next = '0;
        end
        else if (ctl.ins)
        begin
            valid_next[free_idx] = 1'b1;
            level_next           = level_reg + 1'b1;
        end
        else if (ctl.rem && hit)
        begin
            valid_next[hit_idx] = 1'b0;
            level_next          = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            level_reg <= level_next;
        end
    end

    // Slot ids, no reset: a slot is only read while its valid bit is set
    always_ff @(posedge clk)
    begin
        if (ctl.ins && !ctl.clr)
        begin
            ids_reg[free_idx] <= ctl.ins_id;
        end
    end

    // Level tracks the valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(level_reg) == $countones(valid_reg))
        else $error("running level out of step with valid bits");

    // Insert and remove never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.rem))
        else $error("insert and remove in the same cycle");

    // Insert only into a set with a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |-> !(&valid_reg))
        else $error("insert into a full running set");

endmodule

`default_nettype wire

// File: rtl/core/bounded_task_dispatcher.sv
// Top level of the bounded task dispatcher: command sequencer, pending id
// queue memory and result register. Depends on btd_pkg and btd_run_set.
`default_nettype none

//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  task     | task_valid, task_ready, task_item        | in
//  result   | result_valid, result_ready, result_item  | out
//  cfg      | cfg_we, cfg_data (max_running)           | in
//
//  A task is taken in the idle state and executed in the execute state; a
//  finish or fail that starts the queue head goes on to the start state,
//  which takes the head from the queue memory's registered read. Refill
//  passes through the start state once per started task, one queue read
//  per start. The sequencer holds in its execute and start states while
//  an untaken result sits in the output register. Reset clears both sets;
//  no clearing pass is needed.

module bounded_task_dispatcher (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       task_valid,
    output logic                            task_ready,
    input  wire btd_pkg::task_item_t        task_item,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output btd_pkg::result_item_t           result_item,
    input  wire logic                       cfg_we,
    input  wire logic [btd_pkg::CFG_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START
    } state_t;

    state_t                          state_reg, state_next;
    logic [btd_pkg::CFG_W-1:0]       max_reg, max_next;
    logic [btd_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [btd_pkg::ID_BITS-1:0]     id_reg, id_next;
    logic [btd_pkg::PEND_AW-1:0]     head_reg, head_next;
    logic [btd_pkg::PEND_AW-1:0]     tail_reg, tail_next;
    logic [btd_pkg::PEND_CNT_W-1:0]  plvl_reg, plvl_next;
    logic                            res_valid_reg, res_valid_next;
    btd_pkg::result_item_t           res_item_reg, res_item_next;

    // Pending queue memory
    logic [btd_pkg::ID_BITS-1:0]     pend_mem [btd_pkg::PEND_DEPTH];
    logic [btd_pkg::ID_BITS-1:0]     rd_data_reg;
    logic                            rd_en;
    logic [btd_pkg::PEND_AW-1:0]     rd_addr;
    logic                            wr_en;

    btd_pkg::run_ctl_t               run_ctl;
    btd_pkg::run_stat_t              run_stat;

    logic                            out_free;
    logic                            emit;
    btd_pkg::result_item_t           emit_item;
    logic [btd_pkg::RUN_CNT_W-1:0]   eff_limit;
    logic [btd_pkg::RUN_CNT_W-1:0]   lvl;
    logic [btd_pkg::RUN_CNT_W-1:0]   lvl_after;
    logic [btd_pkg::PEND_AW-1:0]     head_inc;
    logic [btd_pkg::PEND_AW-1:0]     tail_inc;
    logic                            can_start;

    btd_run_set u_run_set (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (run_ctl),
        .stat  (run_stat)
    );

    assign task_ready   = (state_reg == ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;
    assign out_free     = !res_valid_reg || result_ready;
    assign lvl          = run_stat.level;

    // Limit in force: register capped at the slot count
    always_comb
    begin
        if (int'(max_reg) > btd_pkg::RUN_SLOTS)
        begin
            eff_limit = btd_pkg::RUN_CNT_W'(btd_pkg::RUN_SLOTS);
        end
        else
        begin
            eff_limit = btd_pkg::RUN_CNT_W'(max_reg);
        end
    end

    // Queue pointer wrap
    assign head_inc = (head_reg == btd_pkg::PEND_AW'(btd_pkg::PEND_DEPTH - 1))
                      ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == btd_pkg::PEND_AW'(btd_pkg::PEND_DEPTH - 1))
                      ? '0 : tail_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        plvl_next      = plvl_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        emit           = 1'b0;
        lvl_after      = lvl;
        can_start      = 1'b0;
        run_ctl        = '0;
        run_ctl.ins_id = id_reg;
        run_ctl.rem_id = id_reg;

        emit_item.action        = btd_pkg::ACT_REJECT;
        emit_item.out_task_id   = id_reg;
        emit_item.last          = 1'b1;
        emit_item.running_count = lvl;
        emit_item.pending_count = plvl_reg;

        if (cfg_we)
        begin
            max_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (task_valid)
                begin
                    cmd_next   = task_item.cmd;
                    id_next    = task_item.task_id;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    unique case (cmd_reg)
                        btd_pkg::CMD_ADD:
                        begin
                            emit = 1'b1;
                            if (max_reg == '0)
                            begin
                                // inline run still occupies a slot
                                if (!run_stat.full)
                                begin
                                    run_ctl.ins             = 1'b1;
                                    emit_item.action        = btd_pkg::ACT_INLINE;
                                    emit_item.running_count = lvl + 1'b1;
                                end
                            end
                            else if (lvl < eff_limit)
                            begin
                                run_ctl.ins             = 1'b1;
                                emit_item.action        = btd_pkg::ACT_START;
                                emit_item.running_count = lvl + 1'b1;
                            end
                            else if (plvl_reg <
                                     btd_pkg::PEND_CNT_W'(btd_pkg::PEND_DEPTH))
                            begin
                                wr_en                   = 1'b1;
                                tail_next               = tail_inc;
                                plvl_next               = plvl_reg + 1'b1;
                                emit_item.action        = btd_pkg::ACT_QUEUED;
                                emit_item.pending_count = plvl_reg + 1'b1;
                            end
                        end

                        btd_pkg::CMD_FINISHED,
                        btd_pkg::CMD_FAILED:
                        begin
                            emit        = 1'b1;
                            run_ctl.rem = run_stat.hit;
                            if (run_stat.hit)
                            begin
                                lvl_after        = lvl - 1'b1;
                                emit_item.action = (cmd_reg == btd_pkg::CMD_FINISHED)
                                                   ? btd_pkg::ACT_FINALIZE
                                                   : btd_pkg::ACT_DELETE;
                            end
                            else
                            begin
                                emit_item.action = btd_pkg::ACT_UNKNOWN;
                            end
                            emit_item.running_count = lvl_after;
                            can_start = (lvl_after < eff_limit) && (plvl_reg != '0);
                            emit_item.last = !can_start;
                            if (can_start)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_START;
                            end
                        end

                        btd_pkg::CMD_KILL:
                        begin
                            emit                    = 1'b1;
                            run_ctl.clr             = 1'b1;
                            head_next               = '0;
                            tail_next               = '0;
                            plvl_next               = '0;
                            emit_item.action        = btd_pkg::ACT_CLEARED;
                            emit_item.out_task_id   = '0;
                            emit_item.running_count = '0;
                            emit_item.pending_count = '0;
                        end

                        btd_pkg::CMD_REFILL:
                        begin
                            // no result when nothing can start
                            can_start = (lvl < eff_limit) && (plvl_reg != '0);
                            if (can_start)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_START;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_START:
            begin
                // start the queue head held in the read data register
                if (out_free)
                begin
                    emit                    = 1'b1;
                    run_ctl.ins             = 1'b1;
                    run_ctl.ins_id          = rd_data_reg;
                    head_next               = head_inc;
                    plvl_next               = plvl_reg - 1'b1;
                    emit_item.action        = btd_pkg::ACT_START;
                    emit_item.out_task_id   = rd_data_reg;
                    emit_item.running_count = lvl + 1'b1;
                    emit_item.pending_count = plvl_reg - 1'b1;
                    can_start = (cmd_reg == btd_pkg::CMD_REFILL)
                                && ((lvl + 1'b1) < eff_limit)
                                && (plvl_reg != btd_pkg::PEND_CNT_W'(1));
                    emit_item.last = !can_start;
                    if (can_start)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register
        res_item_next  = emit ? emit_item : res_item_reg;
        res_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : res_valid_reg);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= btd_pkg::MAX_RUNNING_RESET;
            cmd_reg       <= '0;
            id_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            plvl_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            plvl_reg      <= plvl_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    // Queue memory: one write or one registered read per cycle, never both
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_mem[tail_reg] <= id_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= pend_mem[rd_addr];
        end
    end

    // Queue level within depth
    assert property (@(posedge clk) disable iff (!rst_n)
        plvl_reg <= btd_pkg::PEND_CNT_W'(btd_pkg::PEND_DEPTH))
        else $error("pending level beyond queue depth");

    // Empty or full queue has coinciding pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (plvl_reg == '0 || plvl_reg == btd_pkg::PEND_CNT_W'(btd_pkg::PEND_DEPTH))
        |-> (head_reg == tail_reg))
        else $error("queue pointers out of step with level");

    // A result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrites an untaken result");

    // Queue is read only when it holds something
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (plvl_reg != '0))
        else $error("read from an empty queue");

    // Write and read never meet in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("queue write and read in the same cycle");

endmodule

`default_nettype wire
